@@ hdl/uqsd_pkg.sv @@
// Shared types and constants for the URL query string decoder.
// Character codes, parser mode and escape enums, the result struct and hex decode.
// No dependencies.
`default_nettype none

package uqsd_pkg;

  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned TUSER_W = 5;

  typedef enum logic [1:0] {
    MODE_QMARK = 2'd0,
    MODE_KEY   = 2'd1,
    MODE_VALUE = 2'd2,
    MODE_ERROR = 2'd3
  } uqsd_mode_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HI   = 2'd1,
    ESC_LO   = 2'd2
  } uqsd_esc_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       is_value;
    logic       key_end;
    logic       pair_end;
    logic       error;
    logic       finished;
  } uqsd_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } uqsd_hex_t;

  function automatic uqsd_hex_t hex_decode(input logic [7:0] c);
    uqsd_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      // 'A'..'F' and 'a'..'f' share the low nibble 1..6
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

@@ hdl/uqsd_parser.sv @@
// Parser state machine: decodes one query string byte per enabled cycle.
// Holds parse mode, escape step and pending high nibble; emits one result per byte.
// Depends on uqsd_pkg.
`default_nettype none

module uqsd_parser (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step_en,
  input  wire [7:0]            in_byte,
  input  wire                  in_last,
  output uqsd_pkg::uqsd_res_t  res
);
  import uqsd_pkg::*;

  uqsd_mode_t mode_r, mode_nxt, mode_go;
  uqsd_esc_t  esc_r, esc_nxt, esc_go;
  logic [3:0] nib_r, nib_nxt, nib_go;
  uqsd_hex_t  hex;
  logic       err;
  logic       valid, kend, pend, isval;
  logic [7:0] data;
  logic       in_value;

  assign hex      = hex_decode(in_byte);
  assign in_value = (mode_r == MODE_VALUE);

  // Decode the byte against the current state
  always_comb begin
    err     = 1'b0;
    data    = 8'd0;
    valid   = 1'b0;
    kend    = 1'b0;
    pend    = 1'b0;
    mode_go = mode_r;
    esc_go  = esc_r;
    nib_go  = nib_r;
    unique case (mode_r)
      MODE_QMARK: begin
        if (in_byte == CH_QMARK) mode_go = MODE_KEY;
        else                     err = 1'b1;
      end
      MODE_KEY, MODE_VALUE: begin
        priority if (esc_r == ESC_HI) begin
          if (!hex.ok) err = 1'b1;
          else begin
            nib_go = hex.val;
            esc_go = ESC_LO;
          end
        end else if (esc_r == ESC_LO) begin
          if (!hex.ok) err = 1'b1;
          else begin
            data   = {nib_r, hex.val};
            valid  = 1'b1;
            esc_go = ESC_NONE;
          end
        end else if (in_byte == CH_PCT) begin
          esc_go = ESC_HI;
        end else if (in_byte == CH_PLUS) begin
          data  = CH_SPACE;
          valid = 1'b1;
        end else if (in_byte == CH_AMP) begin
          if (in_value) begin
            pend    = 1'b1;
            mode_go = MODE_KEY;
          end else begin
            err = 1'b1;
          end
        end else if (in_byte == CH_EQUAL && !in_value) begin
          kend    = 1'b1;
          mode_go = MODE_VALUE;
          pend    = in_last;
        end else begin
          data  = in_byte;
          valid = 1'b1;
        end
        // String ends here: close the value, or fault on an open key or escape
        if (!err && in_last && !kend && !pend) begin
          if (esc_go != ESC_NONE || !in_value) err = 1'b1;
          else                                 pend = 1'b1;
        end
      end
      default: err = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    nib_nxt  = nib_r;
    if (step_en) begin
      if (in_last) begin
        mode_nxt = MODE_QMARK;
        esc_nxt  = ESC_NONE;
        nib_nxt  = 4'd0;
      end else begin
        mode_nxt = err ? MODE_ERROR : mode_go;
        esc_nxt  = esc_go;
        nib_nxt  = nib_go;
      end
    end
  end

  // Outputs: a fault blanks the data and every mark except finished
  always_comb begin
    isval          = valid && in_value;
    res.data       = err ? 8'd0 : data;
    res.data_valid = valid && !err;
    res.is_value   = isval && !err;
    res.key_end    = kend && !err;
    res.pair_end   = pend && !err;
    res.error      = err;
    res.finished   = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_QMARK;
      esc_r  <= ESC_NONE;
      nib_r  <= 4'd0;
    end else begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      nib_r  <= nib_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/url_query_string_decoder.sv @@
// URL query string decoder: usage notes
// Input stream: one raw query string byte per beat on in_tdata, in_tlast on the
// final byte. The string must open with '?', then key=value pairs joined by '&';
// '+' decodes to a space and '%' with two hex digits decodes to one byte.
// Output stream: exactly one beat per input beat. out_tdata is the decoded byte,
// out_tuser carries data_valid, is_value, key_end, pair_end and error, and
// out_tlast marks the beat for the final input byte.
// Output: each result is registered; during a stall it waits in the skid register.
// Throughput: one byte per cycle while in_tready is high, set by the parser state update.
// Stall: an output register plus one skid register hold results; in_tready drops
// only once both are full, and rises again when the receiver takes a beat.
// Error: a malformed string raises error on the faulting beat and on every later
// beat up to and including the final one; other marks stay low meanwhile.
// Reset: parser returns to expecting '?', both result registers empty.
// After each final byte the parser restarts for the next string.
// Depends on uqsd_pkg and uqsd_parser.
`default_nettype none

module url_query_string_decoder (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [7:0]                   in_tdata,   // [7:0] in_byte
  input  wire                          in_tlast,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] data
  // [0] data_valid, [1] is_value, [2] key_end, [3] pair_end, [4] error
  output logic [uqsd_pkg::TUSER_W-1:0] out_tuser,
  output logic                         out_tlast
);
  import uqsd_pkg::*;

  logic      in_fire;
  uqsd_res_t new_res;
  uqsd_res_t out_res_r, out_res_nxt;
  uqsd_res_t skid_res_r, skid_res_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  uqsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .res     (new_res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || out_tready) begin
      // Output slot frees up: drain the skid beat first
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
        out_res_nxt   = new_res;
      end
    end else if (in_fire) begin
      // Receiver stalled: park the new beat
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.data;
  assign out_tuser  = {out_res_r.error, out_res_r.pair_end, out_res_r.key_end,
                       out_res_r.is_value, out_res_r.data_valid};
  assign out_tlast  = out_res_r.finished;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a beat while the output register is empty");

  a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("beat accepted during an output stall was not parked");

  a_error_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.error) |->
      (!out_res_r.data_valid && !out_res_r.key_end && !out_res_r.pair_end))
    else $error("error beat carries data or pair marks");
`endif

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking bench for url_query_string_decoder: streams query strings in, checks
// every decoded beat against a cycle-free model of the parser kept in this file.
// Depends on uqsd_pkg and the decoder RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import uqsd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned QUIET_TAIL   = 120;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } query_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = 8'h00;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic [TUSER_W-1:0]  out_tuser;
  logic                out_tlast;

  url_query_string_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  query_beat_t pending_beats[$];
  uqsd_res_t   decoded_q[$];
  logic [7:0]  text_q[$];

  // Parser state mirrored by the predictor
  uqsd_mode_t  mode_q = MODE_QMARK;
  uqsd_esc_t   esc_q  = ESC_NONE;
  logic [3:0]  hi_q   = 4'h0;

  int unsigned mismatches = 0;
  int unsigned accepted_in = 0;
  int unsigned total_beats = 0;
  int unsigned idle_cycles = 0;
  bit          in_taken = 1'b0;
  bit          quiet;

  assign quiet = (pending_beats.size() < QUIET_TAIL);

  // {ok, value} for one hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'b0;
  endfunction

  function automatic uqsd_res_t decode_byte(input logic [7:0] c, input logic fin);
    uqsd_res_t  r;
    logic [4:0] h;
    logic       in_val;
    logic       fault;
    r = '0;
    fault = 1'b0;
    in_val = (mode_q == MODE_VALUE);
    h = hex_nibble(c);
    case (mode_q)
      MODE_QMARK: begin
        if (c == CH_QMARK) mode_q = MODE_KEY;
        else fault = 1'b1;
      end
      MODE_KEY, MODE_VALUE: begin
        if (esc_q == ESC_HI) begin
          if (!h[4]) fault = 1'b1;
          else begin
            hi_q = h[3:0];
            esc_q = ESC_LO;
          end
        end else if (esc_q == ESC_LO) begin
          if (!h[4]) fault = 1'b1;
          else begin
            r.data = {hi_q, h[3:0]};
            r.data_valid = 1'b1;
            esc_q = ESC_NONE;
          end
        end else if (c == CH_PCT) begin
          esc_q = ESC_HI;
        end else if (c == CH_PLUS) begin
          r.data = CH_SPACE;
          r.data_valid = 1'b1;
        end else if (c == CH_AMP) begin
          if (in_val) begin
            r.pair_end = 1'b1;
            mode_q = MODE_KEY;
          end else begin
            fault = 1'b1;
          end
        end else if (c == CH_EQUAL && !in_val) begin
          r.key_end = 1'b1;
          mode_q = MODE_VALUE;
          if (fin) r.pair_end = 1'b1;
        end else begin
          r.data = c;
          r.data_valid = 1'b1;
        end
        r.is_value = r.data_valid && in_val;
        // the final byte must leave a value open with no escape pending
        if (!fault && fin && !r.key_end && !r.pair_end) begin
          if (esc_q != ESC_NONE || !in_val) fault = 1'b1;
          else r.pair_end = 1'b1;
        end
      end
      default: fault = 1'b1;
    endcase
    if (fault) begin
      mode_q = MODE_ERROR;
      r = '0;
    end
    r.error = (mode_q == MODE_ERROR);
    r.finished = fin;
    if (fin) begin
      mode_q = MODE_QMARK;
      esc_q = ESC_NONE;
      hi_q = 4'h0;
    end
    return r;
  endfunction

  task automatic add_byte(input logic [7:0] c, input logic fin);
    query_beat_t b;
    b.ch = c;
    b.fin = fin;
    pending_beats.push_back(b);
  endtask

  task automatic add_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic flush_text();
    for (int i = 0; i < text_q.size(); i++) add_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'("0") + 8'(v);
    if ($urandom_range(0, 1)) return 8'("A") + 8'(v) - 8'd10;
    return 8'("a") + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 6))
      0: return CH_QMARK;
      1: return CH_EQUAL;
      2: return CH_AMP;
      3: return CH_PLUS;
      4: return CH_PCT;
      5: return hex_char(4'($urandom_range(0, 15)));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One decoded character of a key or value: plain byte, plus, or escape
  task automatic add_field_char();
    logic [7:0] c;
    case ($urandom_range(0, 19))
      0, 1, 2: text_q.push_back(CH_PLUS);
      3, 4, 5, 6, 7: begin
        text_q.push_back(CH_PCT);
        text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        text_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      default: begin
        do c = 8'($urandom_range(0, 255));
        while (c == CH_EQUAL || c == CH_AMP || c == CH_PLUS || c == CH_PCT);
        text_q.push_back(c);
      end
    endcase
  endtask

  task automatic build_query();
    int unsigned npairs;
    npairs = $urandom_range(1, 4);
    text_q.push_back(CH_QMARK);
    for (int p = 0; p < npairs; p++) begin
      if (p != 0) text_q.push_back(CH_AMP);
      repeat ($urandom_range(0, 4)) add_field_char();
      text_q.push_back(CH_EQUAL);
      repeat ($urandom_range(0, 5)) add_field_char();
    end
    if ($urandom_range(0, 3) == 0) text_q.push_back(CH_AMP);
  endtask

  task automatic corrupt_query();
    int unsigned idx;
    idx = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 2))
      0: text_q[idx] = pick_special();
      1: while (text_q.size() > idx + 1) void'(text_q.pop_back());
      default: text_q.insert(idx, pick_special());
    endcase
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 8)) text_q.push_back(pick_special());
  endtask

  // Input acceptance and prediction
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      decoded_q.push_back(decode_byte(in_tdata, in_tlast));
      accepted_in++;
    end
  end

  // Driver: change inputs on the falling edge only
  int unsigned send_gap = 0;
  always @(negedge clk) begin : drive
    query_beat_t b;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 6) - 1;
        in_tvalid <= 1'b0;
        in_tdata <= 8'($urandom_range(0, 255));
      end else begin
        b = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= b.ch;
        in_tlast <= b.fin;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the block
  int unsigned hold_cnt = 0;
  bit          hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (!hold_done && accepted_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_cnt = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(1, 6) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin : monitor
    uqsd_res_t got;
    uqsd_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.data       = out_tdata;
      got.data_valid = out_tuser[0];
      got.is_value   = out_tuser[1];
      got.key_end    = out_tuser[2];
      got.pair_end   = out_tuser[3];
      got.error      = out_tuser[4];
      got.finished   = out_tlast;
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual data=%h tuser=%b tlast=%b",
                 $realtime, out_tdata, out_tuser, out_tlast);
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected data=%h v=%b val=%b kend=%b pend=%b err=%b fin=%b",
                   $realtime, want.data, want.data_valid, want.is_value, want.key_end,
                   want.pair_end, want.error, want.finished);
          $display("%0t:   actual data=%h v=%b val=%b kend=%b pend=%b err=%b fin=%b",
                   $realtime, got.data, got.data_valid, got.is_value, got.key_end,
                   got.pair_end, got.error, got.finished);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned sel;
    // only a question mark
    add_text("?", 1'b1);
    // missing question mark
    add_text("x", 1'b1);
    // escapes in both cases, plus, byte extremes, final ampersand
    add_text("?%4A+", 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(CH_EQUAL, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_text("=%f0&", 1'b1);
    // ampersand in key
    add_text("?a&", 1'b1);
    // bad hex digit
    add_text("?%g", 1'b1);
    // end inside escape
    add_text("?k=%4", 1'b1);
    // end inside key on a completed escape
    add_text("?%41", 1'b1);
    // final equals sign
    add_text("?k=", 1'b1);

    while (pending_beats.size() < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel == 9) begin
        build_noise();
      end else begin
        build_query();
        if (sel >= 7) corrupt_query();
      end
      flush_text();
    end
    total_beats = pending_beats.size();

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_in != total_beats || decoded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
